@@ hw/rtl/prms_pkg.sv @@
// Shared constants and types for the peak/RMS level meter.
// Used by every module of the meter; depends on nothing else.
package prms_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int MAG_W         = SAMPLE_BITS + 1;
  localparam int LEVEL_W       = 16;
  localparam int ALPHA_W       = 16;
  localparam int BLOCK_MAX_DEF = 4096;
  localparam int JQ_DEPTH      = 2;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 16'd6554;
  localparam logic [ADDR_W-3:0]   REG_ALPHA   = 1'b0;

  typedef struct packed {
    logic [LEVEL_W-1:0] smoothed_peak;
    logic [LEVEL_W-1:0] smoothed_rms;
    logic [LEVEL_W-1:0] block_peak;
    logic [LEVEL_W-1:0] block_rms;
    logic               block_overlong;
  } result_t;

endpackage

@@ hw/rtl/prms_front.sv @@
// Front end of the level meter: sample magnitude, peak, sum of squares and count.
// Hands a finished block to the job queue. Depends on prms_pkg.
module prms_front import prms_pkg::*; #(
  parameter int BLOCK_MAX = BLOCK_MAX_DEF,
  localparam int CNT_W    = $clog2(BLOCK_MAX + 1),
  localparam int SUM_W    = 2 * SAMPLE_BITS - 1 + CNT_W,
  localparam int JOB_W    = MAG_W + SUM_W + CNT_W + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          job_push,
  output logic [JOB_W-1:0]              job_data
);

  logic [MAG_W-1:0]   peak_r, peak_nxt, peak_upd;
  logic [SUM_W-1:0]   sum_r, sum_nxt, sum_upd;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_upd;
  logic               sat_r, sat_nxt, sat_upd;
  logic [MAG_W-1:0]   ext;
  logic [MAG_W-1:0]   mag;
  logic [2*MAG_W-1:0] sq;
  logic               below;

  always_comb begin
    ext      = {sample[SAMPLE_BITS-1], sample};
    mag      = sample[SAMPLE_BITS-1] ? (~ext + MAG_W'(1)) : ext;
    sq       = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
    below    = cnt_r < CNT_W'(BLOCK_MAX);
    peak_upd = (mag > peak_r) ? mag : peak_r;
    sum_upd  = below ? (sum_r + SUM_W'(sq)) : sum_r;
    cnt_upd  = below ? (cnt_r + CNT_W'(1)) : cnt_r;
    sat_upd  = sat_r | ~below;

    peak_nxt = peak_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    if (accept) begin
      if (last) begin
        peak_nxt = '0;
        sum_nxt  = '0;
        cnt_nxt  = '0;
        sat_nxt  = 1'b0;
      end else begin
        peak_nxt = peak_upd;
        sum_nxt  = sum_upd;
        cnt_nxt  = cnt_upd;
        sat_nxt  = sat_upd;
      end
    end
  end

  assign job_push = accept & last;
  assign job_data = {peak_upd, sum_upd, cnt_upd, sat_upd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      sat_r  <= 1'b0;
    end else begin
      peak_r <= peak_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      sat_r  <= sat_nxt;
    end
  end

endmodule

@@ hw/rtl/prms_jobq.sv @@
// Short queue of finished blocks between the front end and the back end.
// Depends on prms_pkg for its default depth.
module prms_jobq import prms_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = JQ_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/prms_back.sv @@
// Back end of the level meter: divide, square root, smoothing and the result register.
// Takes blocks from the job queue. Depends on prms_pkg.
module prms_back import prms_pkg::*; #(
  parameter int BLOCK_MAX = BLOCK_MAX_DEF,
  localparam int CNT_W    = $clog2(BLOCK_MAX + 1),
  localparam int SUM_W    = 2 * SAMPLE_BITS - 1 + CNT_W,
  localparam int JOB_W    = MAG_W + SUM_W + CNT_W + 1,
  localparam int ROOT_W   = MAG_W,
  localparam int RAD_W    = 2 * ROOT_W,
  localparam int ACC_W    = MAG_W + ALPHA_W + 1,
  localparam int STEP_W   = $clog2(SUM_W)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ALPHA_W-1:0] alpha,
  input  logic               job_empty,
  input  logic [JOB_W-1:0]   job_data,
  output logic               job_pop,
  input  logic               pop,
  output logic               empty,
  output result_t            result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_MPK  = 3'd3;
  localparam logic [2:0] S_MRM  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [MAG_W-1:0]  pavg_r, pavg_nxt;
  logic [MAG_W-1:0]  ravg_r, ravg_nxt;

  logic [MAG_W-1:0]  peak_r, peak_nxt;
  logic              sat_r, sat_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ROOT_W+1:0] srem_r, srem_nxt;
  logic [ACC_W-1:0]  prod_a_r, prod_a_nxt;
  logic [ACC_W-1:0]  prod_b_r, prod_b_nxt;
  result_t           res_r, res_nxt;

  logic [CNT_W:0]    rem_sh;
  logic              div_ge;
  logic [SUM_W-1:0]  quo_step;
  logic [ROOT_W+1:0] srem_sh;
  logic [ROOT_W+1:0] trial;
  logic              sqrt_ge;
  logic [ROOT_W-1:0] root_step;
  logic [ACC_W-1:0]  inv_alpha;
  logic [ACC_W-1:0]  acc_sum;

  assign empty  = ~out_valid_r;
  assign result = res_r;

  always_comb begin
    // One restoring divide step.
    rem_sh   = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    div_ge   = rem_sh >= {1'b0, den_r};
    quo_step = {quo_r[SUM_W-2:0], div_ge};
    // One square root digit.
    srem_sh   = {srem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
    trial     = {root_r, 2'b01};
    sqrt_ge   = srem_sh >= trial;
    root_step = {root_r[ROOT_W-2:0], sqrt_ge};
    inv_alpha = ACC_W'(1 << ALPHA_W) - ACC_W'(alpha);
    acc_sum   = prod_a_r + prod_b_r;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    pavg_nxt      = pavg_r;
    ravg_nxt      = ravg_r;
    peak_nxt      = peak_r;
    sat_nxt       = sat_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    res_nxt       = res_r;
    job_pop       = 1'b0;

    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          {peak_nxt, quo_nxt, den_nxt, sat_nxt} = job_data;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = div_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        quo_nxt  = quo_step;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          // The mean square never exceeds full scale squared.
          rad_nxt   = RAD_W'(quo_step);
          root_nxt  = '0;
          srem_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        srem_nxt = sqrt_ge ? (srem_sh - trial) : srem_sh;
        root_nxt = root_step;
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = S_MPK;
        end
      end
      S_MPK: begin
        prod_a_nxt = ACC_W'(peak_r) * ACC_W'(alpha);
        prod_b_nxt = ACC_W'(pavg_r) * inv_alpha;
        state_nxt  = S_MRM;
      end
      S_MRM: begin
        pavg_nxt   = MAG_W'(acc_sum >> ALPHA_W);
        prod_a_nxt = ACC_W'(root_r) * ACC_W'(alpha);
        prod_b_nxt = ACC_W'(ravg_r) * inv_alpha;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        ravg_nxt  = MAG_W'(acc_sum >> ALPHA_W);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || pop) begin
          res_nxt.smoothed_peak  = LEVEL_W'(pavg_r);
          res_nxt.smoothed_rms   = LEVEL_W'(ravg_r);
          res_nxt.block_peak     = LEVEL_W'(peak_r);
          res_nxt.block_rms      = LEVEL_W'(root_r);
          res_nxt.block_overlong = sat_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pavg_r      <= '0;
      ravg_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pavg_r      <= pavg_nxt;
      ravg_r      <= ravg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    peak_r   <= peak_nxt;
    sat_r    <= sat_nxt;
    den_r    <= den_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    rad_r    <= rad_nxt;
    root_r   <= root_nxt;
    srem_r   <= srem_nxt;
    prod_a_r <= prod_a_nxt;
    prod_b_r <= prod_b_nxt;
    res_r    <= res_nxt;
  end

endmodule

@@ hw/rtl/block_peak_rms_level_meter.sv @@
// Block peak/RMS level meter, top level. Samples are taken one per cycle while the block
// queue is not full. A block's result comes from a bit-serial divider and a digit-serial
// square root; the back end works on one block while the next one accumulates.
// Reset is synchronous and active low: all sums, counts and averages clear, alpha returns to 6554.
// Depends on prms_pkg, prms_front, prms_jobq and prms_back.
module block_peak_rms_level_meter import prms_pkg::*; #(
  parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // Sample channel.
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] in_audio_sample,
  input  logic                          in_block_last,
  // Result channel.
  output logic                          empty,
  input  logic                          pop,
  output logic [LEVEL_W-1:0]            out_smoothed_peak,
  output logic [LEVEL_W-1:0]            out_smoothed_rms,
  output logic [LEVEL_W-1:0]            out_block_peak,
  output logic [LEVEL_W-1:0]            out_block_rms,
  output logic                          out_block_overlong
);

  localparam int CNT_W = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W = 2 * SAMPLE_BITS - 1 + CNT_W;
  localparam int JOB_W = MAG_W + SUM_W + CNT_W + 1;

  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic               cfg_wr;
  logic               in_accept;
  logic               job_push;
  logic [JOB_W-1:0]   job_wdata;
  logic [JOB_W-1:0]   job_rdata;
  logic               job_pop;
  logic               job_empty;
  result_t            result;

  // The configuration port answers at once; a write lands on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    alpha_nxt = alpha_r;
    if (cfg_wr && paddr[ADDR_W-1:2] == REG_ALPHA) begin
      alpha_nxt = pwdata[ALPHA_W-1:0];
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_ALPHA: prdata = DATA_W'(alpha_r);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else begin
      alpha_r <= alpha_nxt;
    end
  end

  // The sample channel stalls only while the block queue holds two finished
  // blocks that the back end has not yet taken.
  assign in_accept = push & ~full;

  prms_front #(
    .BLOCK_MAX(BLOCK_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .sample   (in_audio_sample),
    .last     (in_block_last),
    .job_push (job_push),
    .job_data (job_wdata)
  );

  prms_jobq #(
    .W     (JOB_W),
    .DEPTH (JQ_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wdata),
    .rd_en   (job_pop),
    .rd_data (job_rdata),
    .full    (full),
    .empty   (job_empty)
  );

  // The back end works on one block at a time and holds its finished word in
  // an output register until it is popped.
  prms_back #(
    .BLOCK_MAX(BLOCK_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha     (alpha_r),
    .job_empty (job_empty),
    .job_data  (job_rdata),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign out_smoothed_peak  = result.smoothed_peak;
  assign out_smoothed_rms   = result.smoothed_rms;
  assign out_block_peak     = result.block_peak;
  assign out_block_rms      = result.block_rms;
  assign out_block_overlong = result.block_overlong;

endmodule

@@ tb/sv/block_peak_rms_level_meter_tb.sv @@
// Self-checking testbench for the block peak/RMS level meter.
// Depends directly only on prms_pkg and block_peak_rms_level_meter.
module block_peak_rms_level_meter_tb;
  import prms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles that are enough for the back end to finish any work on a block.
  localparam int SETTLE_CYCLES = 100;
  // Cycles without any accepted word before the run is declared hung. The slowest
  // correct stretch is the long receiver hold-off plus one block latency.
  localparam int HANG_LIMIT    = 20000;
  localparam int HOLDOFF_LEN   = 400;
  localparam int PHASE_ITEMS   = 140;

  localparam logic [ADDR_W-1:0] ALPHA_ADDR = {REG_ALPHA, 2'b00};

  // One row of the directed table. When fixed is set, the expected result is
  // taken from the row itself instead of from the level predictor.
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          last;
    bit                            fixed;
    result_t                       want;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_W-1:0]             paddr = '0;
  logic [DATA_W-1:0]             pwdata = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;
  logic                          push = 1'b0;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] in_audio_sample = '0;
  logic                          in_block_last = 1'b0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [LEVEL_W-1:0]            out_smoothed_peak;
  logic [LEVEL_W-1:0]            out_smoothed_rms;
  logic [LEVEL_W-1:0]            out_block_peak;
  logic [LEVEL_W-1:0]            out_block_rms;
  logic                          out_block_overlong;

  // Expected block results, oldest first.
  result_t level_results_q[$];

  // Predictor copy of the meter state and of the smoothing register.
  int unsigned     run_peak;
  longint unsigned run_sqsum;
  int unsigned     run_count;
  bit              run_overlong;
  longint unsigned avg_peak;
  longint unsigned avg_rms;
  longint unsigned alpha_q16;

  // Traffic shaping, set by the stimulus process and read by the others.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_reqs   = 0;

  int err_count      = 0;
  int samples_sent   = 0;
  int blocks_sent    = 0;
  int results_seen   = 0;
  int overlong_seen  = 0;
  int idle_cycles    = 0;

  // The directed table: zero, both full-scale extremes, bit patterns that toggle
  // every sample bit, short multi-sample blocks with truncating division, and a
  // block held at the most negative sample. Only the first two rows carry a
  // result that is obvious by hand: silence, then -32768 smoothed from zero with
  // the reset alpha, which gives 32768*6554/65536 = 3277 for both averages.
  stim_row_t dir_rows [19] = '{
    '{16'sd0,       1'b1, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{-16'sd32768,  1'b1, 1'b1, '{16'd3277, 16'd3277, 16'd32768, 16'd32768, 1'b0}},
    '{16'sd32767,   1'b1, 1'b0, '0},
    '{-16'sd1,      1'b0, 1'b0, '0},
    '{16'sd1,       1'b1, 1'b0, '0},
    '{16'sh5555,    1'b0, 1'b0, '0},
    '{-16'sd21846,  1'b1, 1'b0, '0},
    '{16'sd3,       1'b0, 1'b0, '0},
    '{-16'sd4,      1'b1, 1'b0, '0},
    '{16'sd0,       1'b0, 1'b0, '0},
    '{16'sd0,       1'b0, 1'b0, '0},
    '{16'sd32767,   1'b1, 1'b0, '0},
    '{-16'sd32768,  1'b0, 1'b0, '0},
    '{-16'sd32768,  1'b0, 1'b0, '0},
    '{-16'sd32768,  1'b1, 1'b0, '0},
    '{16'sd100,     1'b0, 1'b0, '0},
    '{-16'sd200,    1'b0, 1'b0, '0},
    '{16'sd300,     1'b0, 1'b0, '0},
    '{16'sd7,       1'b1, 1'b0, '0}
  };

  block_peak_rms_level_meter #(
    .BLOCK_MAX(BLOCK_MAX_DEF)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .push               (push),
    .full               (full),
    .in_audio_sample    (in_audio_sample),
    .in_block_last      (in_block_last),
    .empty              (empty),
    .pop                (pop),
    .out_smoothed_peak  (out_smoothed_peak),
    .out_smoothed_rms   (out_smoothed_rms),
    .out_block_peak     (out_block_peak),
    .out_block_rms      (out_block_rms),
    .out_block_overlong (out_block_overlong)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Floor square root by building the root one bit at a time from the top.
  // The mean of squares never exceeds 2^30, so the root fits in 17 bits.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Exponential smoothing in Q0.16: the new value weighted by alpha, the old
  // average by its complement, truncated by the final shift.
  function automatic longint unsigned smooth_level(input longint unsigned x,
                                                   input longint unsigned prev);
    return (x * alpha_q16 + prev * (64'd65536 - alpha_q16)) >> 16;
  endfunction

  // Level predictor: folds one accepted sample into the running block state and,
  // on the last sample of a block, produces the block result and clears the block.
  task automatic meter_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                              input logic last, output bit done, output result_t res);
    int              s;
    int unsigned     mag;
    longint unsigned bpeak;
    longint unsigned brms;
    s = smp;
    mag = (s < 0) ? -s : s;
    done = 1'b0;
    res = '0;
    if (mag > run_peak) run_peak = mag;
    // Once the count is full, later samples still raise the peak but no longer
    // add to the sum of squares, and the block is flagged as overlong.
    if (run_count < BLOCK_MAX_DEF) begin
      run_sqsum += longint'(mag) * mag;
      run_count++;
    end else begin
      run_overlong = 1'b1;
    end
    if (last) begin
      bpeak = run_peak;
      brms = floor_root(run_sqsum / run_count);
      avg_peak = smooth_level(bpeak, avg_peak);
      avg_rms = smooth_level(brms, avg_rms);
      res.smoothed_peak  = avg_peak[LEVEL_W-1:0];
      res.smoothed_rms   = avg_rms[LEVEL_W-1:0];
      res.block_peak     = bpeak[LEVEL_W-1:0];
      res.block_rms      = brms[LEVEL_W-1:0];
      res.block_overlong = run_overlong;
      done = 1'b1;
      run_peak = 0;
      run_sqsum = 0;
      run_count = 0;
      run_overlong = 1'b0;
    end
  endtask

  // Offers one sample word, after idle cycles that each come with the sender's
  // idle percentage, and waits for the edge that accepts it. The expectation is
  // queued in the same time step, long before the block can produce the result.
  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] smp, input logic last,
                           input bit fixed = 1'b0, input result_t want = '0);
    bit      done;
    result_t res;
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    in_audio_sample <= smp;
    in_block_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    meter_sample(smp, last, done, res);
    samples_sent++;
    if (done) begin
      level_results_q.push_back(fixed ? want : res);
      blocks_sent++;
    end
  endtask

  // Stops offering words and waits until every expected result has arrived.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (level_results_q.size() != 0) @(posedge clk);
  endtask

  // One configuration transfer: setup cycle, then access until pready.
  task automatic cfg_xfer(input bit wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_alpha_readback(input logic [ALPHA_W-1:0] want);
    logic [DATA_W-1:0] rd;
    cfg_xfer(1'b0, ALPHA_ADDR, '0, rd);
    if (rd !== DATA_W'(want)) begin
      $display("%0t: alpha readback expected %0d, actual %0d", $time, want, rd);
      err_count++;
    end
  endtask

  // Changes the smoothing weight only while the meter is idle: all results in,
  // then enough quiet cycles for the back end to have finished any partial work.
  task automatic set_alpha(input logic [ALPHA_W-1:0] val);
    logic [DATA_W-1:0] rd;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_xfer(1'b1, ALPHA_ADDR, DATA_W'(val), rd);
    alpha_q16 = val;
    check_alpha_readback(val);
  endtask

  // Sample mix: full-scale extremes, values near zero, quiet material and
  // arbitrary bit patterns so that every sample bit toggles.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0: v = -32768;
      1: v = 32767;
      2: v = int'($urandom_range(2)) - 1;
      3, 4, 5: v = int'($urandom_range(511)) - 256;
      default: v = $urandom();
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Mostly short blocks, now and then a longer one.
  function automatic int pick_block_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  // The last block is cut short so that exactly n_items samples are sent.
  task automatic send_random_blocks(input int n_items);
    int count;
    int len;
    count = 0;
    while (count < n_items) begin
      len = pick_block_len();
      if (len > n_items - count) len = n_items - count;
      for (int i = 0; i < len; i++) begin
        send_word(pick_sample(), i == len - 1);
      end
      count += len;
    end
  endtask

  // Result side: checks each accepted word against the oldest expectation and
  // drives pop, with random stalls and the occasional long hold-off.
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  int holdoff_left = 0;
  int holdoff_seen = 0;

  always @(posedge clk) begin
    result_t want;
    if (pop && !empty) begin
      results_seen++;
      if (out_block_overlong) overlong_seen++;
      if (level_results_q.size() == 0) begin
        $display("%0t: result word with nothing expected (peak %0d, rms %0d)",
                 $time, out_block_peak, out_block_rms);
        err_count++;
      end else begin
        want = level_results_q.pop_front();
        check_field("smoothed_peak", want.smoothed_peak, out_smoothed_peak);
        check_field("smoothed_rms", want.smoothed_rms, out_smoothed_rms);
        check_field("block_peak", want.block_peak, out_block_peak);
        check_field("block_rms", want.block_rms, out_block_rms);
        check_field("block_overlong", want.block_overlong, out_block_overlong);
      end
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (holdoff_left > 0) begin
      pop <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_seen != holdoff_reqs) begin
      holdoff_seen <= holdoff_reqs;
      holdoff_left <= HOLDOFF_LEN;
      pop <= 1'b0;
    end else begin
      pop <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Hang detection: any stretch without an accepted word on either channel that
  // is far longer than the slowest correct behavior ends the run.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    run_peak = 0;
    run_sqsum = 0;
    run_count = 0;
    run_overlong = 1'b0;
    avg_peak = 0;
    avg_rms = 0;
    alpha_q16 = ALPHA_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The smoothing weight must come out of reset at its default of about 0.1.
    check_alpha_readback(ALPHA_RESET);

    // Directed table, back to back with the reset weight.
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].smp, dir_rows[i].last, dir_rows[i].fixed, dir_rows[i].want);
    end

    // Heaviest weight: the averages follow each block almost exactly. No idling.
    set_alpha(16'hFFFF);
    send_random_blocks(PHASE_ITEMS);

    // Lightest weight, so the averages barely move; the sender idles often.
    set_alpha(16'd1);
    send_idle_pct = 46;
    send_random_blocks(PHASE_ITEMS);

    // Random weight; now the receiver stalls often and the sender never idles.
    set_alpha(ALPHA_W'($urandom_range(1, 65535)));
    send_idle_pct = 0;
    recv_stall_pct = 46;
    send_random_blocks(PHASE_ITEMS);

    // Back pressure: the receiver holds off for a long stretch while one-sample
    // blocks keep coming, so the job queue fills and the input must stall. Then
    // the sender pauses until every result is out before going on.
    recv_stall_pct = 0;
    holdoff_reqs++;
    for (int i = 0; i < 40; i++) begin
      send_word(pick_sample(), 1'b1);
    end
    wait_drained();
    send_random_blocks(60);

    // Random weight, both sides idling.
    set_alpha(ALPHA_W'($urandom_range(1, 65535)));
    send_idle_pct = 23;
    recv_stall_pct = 23;
    send_random_blocks(PHASE_ITEMS);

    // Half weight for a short stretch.
    set_alpha(16'h8000);
    send_random_blocks(40);

    // Back to the reset weight for a last random stretch.
    set_alpha(ALPHA_RESET);
    send_random_blocks(PHASE_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples in %0d blocks; checked %0d results, %0d of them overlong.",
             samples_sent, blocks_sent, results_seen, overlong_seen);
    $display("Smoothing weights included 1, 65535 and the reset value, under mixed idling.");
    if (err_count == 0 && level_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_count,
               level_results_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/prms_pkg.sv
hw/rtl/prms_front.sv
hw/rtl/prms_jobq.sv
hw/rtl/prms_back.sv
hw/rtl/block_peak_rms_level_meter.sv
tb/sv/block_peak_rms_level_meter_tb.sv
